// ===== rtl/b64d_pkg.sv =====
// Shared types, constants and character classification for the base64 stream decoder.
`timescale 1ns / 1ps
package b64d_pkg;

   // Width of the decoded byte counter
   localparam int LenBits = 16;
   // Wide enough to compare a grown count against the 16-bit capacity at any LenBits
   localparam int CmpBits = LenBits + 17;
   localparam int CapBits = 16;
   localparam int MaxResults = 4;

   // Classes beyond the sextet values
   localparam logic [6:0] ClsSkip = 7'd64;
   localparam logic [6:0] ClsPad  = 7'd65;
   localparam logic [6:0] ClsBad  = 7'd66;

   localparam logic [7:0] ChrNewline = 8'd10;

   // CSR register byte offsets
   localparam logic [2:0] AddrCapacity = 3'd0;

   typedef logic [LenBits-1:0] len_type;
   typedef logic [CapBits-1:0] cap_type;

   typedef enum logic [1:0] {
      StData = 2'd0,
      StDone = 2'd1,
      StBad  = 2'd2,
      StOvf  = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      status_type  status;
      logic [15:0] total_length;
      logic        last_of_run;
   } result_type;

   // Results of one item, in order from entry 0, with their count
   typedef struct packed {
      result_type [MaxResults-1:0] ent;
      logic [2:0]                  cnt;
   } burst_type;

   // Map a raw byte to its sextet value or to one of the special classes
   function automatic logic [6:0] classify(input logic [7:0] c);
      logic [6:0] v;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v = 7'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = 7'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = 7'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         v = 7'd62;
      end else if (c == 8'h2F) begin
         v = 7'd63;
      end else if (c == ChrNewline) begin
         v = ClsSkip;
      end else if (c == 8'h3D) begin
         v = ClsPad;
      end else begin
         v = ClsBad;
      end
      return v;
   endfunction

   // True when k more bytes would exceed the capacity or the counter range
   function automatic logic room_over(input len_type bytes, input logic [1:0] k,
                                      input cap_type cap);
      logic [LenBits:0] sum;
      sum = {1'b0, bytes} + (LenBits+1)'(k);
      return sum[LenBits] | (CmpBits'(sum) > CmpBits'(cap));
   endfunction

endpackage

// ===== rtl/base64_stream_decoder_top.sv =====
// Top level of the base64 stream decoder: input register, decoder core, result buffer, CSR.
// The first result of an item is offered by the result buffer after the core loads it there.
// Throughput: one item per cycle while each item gives at most one result and rsp_ready is
// not held low; an item that gives k results holds the single result port until all have left;
// the next item with results waits; items giving none (newline, mid-group sextets) never stall.
// Reset: synchronous, active high; clears message state, the buffers and sets capacity to 65535.
`timescale 1ns / 1ps
module base64_stream_decoder_top import b64d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_total_length,
   output logic        rsp_last_of_run,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic       vld_ff, vld_in;
   logic [7:0] chr_ff, chr_in;
   logic       eom_ff, eom_in;
   logic       advance;
   logic       buf_free;
   cap_type    capacity;
   burst_type  burst;
   result_type rsp_data;

   // Move the held item into the core when the result buffer can take its burst,
   // or at once when it gives no result
   assign advance   = vld_ff & (buf_free | (burst.cnt == 3'd0));
   assign req_ready = ~vld_ff | advance;

   // Input register
   always_comb begin
      vld_in = vld_ff;
      chr_in = chr_ff;
      eom_in = eom_ff;
      if (req_ready) begin
         vld_in = req_valid;
         chr_in = req_char_code;
         eom_in = req_end_of_message;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      chr_ff <= chr_in;
      eom_ff <= eom_in;
   end

   b64d_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity)
   );

   b64d_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .char_code      (chr_ff),
      .end_of_message (eom_ff),
      .capacity       (capacity),
      .burst          (burst)
   );

   b64d_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && (burst.cnt != 3'd0)),
      .burst     (burst),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_byte     = rsp_data.out_byte;
   assign rsp_status       = rsp_data.status;
   assign rsp_total_length = rsp_data.total_length;
   assign rsp_last_of_run  = rsp_data.last_of_run;

endmodule

// ===== rtl/b64d_csr.sv =====
// APB-style configuration register holding the output capacity.
`timescale 1ns / 1ps
module b64d_csr import b64d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cap_type     capacity
);

   cap_type cap_ff, cap_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & (csr_paddr == AddrCapacity);

   // Take new capacity on the access cycle of a write
   always_comb begin
      cap_in = cap_ff;
      if (wr_en) begin
         cap_in = csr_pwdata[CapBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '1;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // Read back
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == AddrCapacity) begin
         csr_prdata = 32'(cap_ff);
      end
   end

   assign capacity = cap_ff;

endmodule

// ===== rtl/b64d_core.sv =====
// Decoder state and the per-item logic that builds the burst of results.
`timescale 1ns / 1ps
module b64d_core import b64d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] char_code,
   input  logic       end_of_message,
   input  cap_type    capacity,
   output burst_type  burst
);

   logic [23:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   len_type     bytes_ff, bytes_in;
   logic        pad_ff, pad_in;
   logic        err_ff, err_in;

   logic [6:0]  cls;
   logic [23:0] acc_new;
   result_type [MaxResults-1:0] res;
   logic [2:0]  n;

   assign cls = classify(char_code);
   assign acc_new = {acc_ff[17:0], cls[5:0]};

   // Work out results and next state for the item in the input register
   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      bytes_in = bytes_ff;
      pad_in   = pad_ff;
      err_in   = err_ff;
      res      = '0;
      n        = '0;

      if (!err_ff && !pad_ff) begin
         if (cls == ClsBad) begin
            res[0].status = StBad;
            n      = 3'd1;
            err_in = 1'b1;
         end else if (cls == ClsPad) begin
            pad_in = 1'b1;
         end else if (cls != ClsSkip) begin
            if (cnt_ff == 2'd3) begin
               acc_in = '0;
               cnt_in = '0;
               if (room_over(bytes_ff, 2'd3, capacity)) begin
                  res[0].status = StOvf;
                  n      = 3'd1;
                  err_in = 1'b1;
               end else begin
                  bytes_in = bytes_ff + LenBits'(3);
                  res[0].out_byte = acc_new[23:16];
                  res[1].out_byte = acc_new[15:8];
                  res[2].out_byte = acc_new[7:0];
                  n = 3'd3;
               end
            end else begin
               acc_in = acc_new;
               cnt_in = cnt_ff + 2'd1;
            end
         end
      end

      // Flush a partial group and report the count at the end of the message
      if (end_of_message) begin
         if (!err_in) begin
            if (cnt_in == 2'd3) begin
               if (room_over(bytes_in, 2'd2, capacity)) begin
                  res[n[1:0]].status = StOvf;
                  n      = n + 3'd1;
                  err_in = 1'b1;
               end else begin
                  res[n[1:0]].out_byte = acc_in[17:10];
                  n = n + 3'd1;
                  res[n[1:0]].out_byte = acc_in[9:2];
                  n = n + 3'd1;
                  bytes_in = bytes_in + LenBits'(2);
               end
            end else if (cnt_in == 2'd2) begin
               if (room_over(bytes_in, 2'd1, capacity)) begin
                  res[n[1:0]].status = StOvf;
                  n      = n + 3'd1;
                  err_in = 1'b1;
               end else begin
                  res[n[1:0]].out_byte = acc_in[11:4];
                  n = n + 3'd1;
                  bytes_in = bytes_in + LenBits'(1);
               end
            end
            if (!err_in) begin
               res[n[1:0]].status       = StDone;
               res[n[1:0]].total_length = 16'(bytes_in);
               n = n + 3'd1;
            end
         end
         acc_in   = '0;
         cnt_in   = '0;
         bytes_in = '0;
         pad_in   = 1'b0;
         err_in   = 1'b0;
      end

      // Mark the final result of the item
      if (n != 3'd0) begin
         res[2'(n - 3'd1)].last_of_run = 1'b1;
      end
   end

   assign burst.ent = res;
   assign burst.cnt = n;

   // Advance message state once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         cnt_ff   <= '0;
         bytes_ff <= '0;
         pad_ff   <= 1'b0;
         err_ff   <= 1'b0;
      end else if (step) begin
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         bytes_ff <= bytes_in;
         pad_ff   <= pad_in;
         err_ff   <= err_in;
      end
   end

endmodule

// ===== rtl/b64d_outbuf.sv =====
// Result register that holds one item's burst and hands it out one result at a time.
`timescale 1ns / 1ps
module b64d_outbuf import b64d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  burst_type  burst,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   result_type [MaxResults-1:0] ent_ff, ent_in;
   logic [2:0] rem_ff, rem_in;
   logic [1:0] idx_ff, idx_in;
   logic       pop;

   assign rsp_valid = (rem_ff != 3'd0);
   assign pop       = rsp_valid & rsp_ready;
   // Room for a new burst once the last held result leaves
   assign free      = (rem_ff == 3'd0) || ((rem_ff == 3'd1) && rsp_ready);
   assign rsp_data  = ent_ff[idx_ff];

   // Load a new burst, else advance through the held one
   always_comb begin
      ent_in = ent_ff;
      rem_in = rem_ff;
      idx_in = idx_ff;
      if (load) begin
         ent_in = burst.ent;
         rem_in = burst.cnt;
         idx_in = '0;
      end else if (pop) begin
         rem_in = rem_ff - 3'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         idx_ff <= '0;
      end else begin
         rem_ff <= rem_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule
